@@ sv/ffc_pkg.sv @@
package ffc_pkg;
	localparam logic [2:0] CMD_F32_F16  = 3'd0;
	localparam logic [2:0] CMD_F16_F32  = 3'd1;
	localparam logic [2:0] CMD_F32_BF16 = 3'd2;
	localparam logic [2:0] CMD_F32_E4M3 = 3'd3;
	localparam logic [2:0] CMD_E4M3_F32 = 3'd4;

	typedef struct packed {
		logic        vld;
		logic [2:0]  cmd;
		logic [31:0] op;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic signed [9:0] ee;
		logic [5:0]  sh;
		logic [4:0]  msb;
	} s1_t;

	typedef struct packed {
		logic        vld;
		logic [2:0]  cmd;
		logic [31:0] op;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic signed [9:0] ee;
		logic [24:0] t;
		logic        rup;
	} s2_t;
endpackage

@@ sv/float_format_converter_top.sv @@
// done rises after a request's valid bit passes through s1_s1, s2_s2 and vld_s3.
// Throughput: one request per cycle; busy is always low.
// The pipeline is fully stateless apart from valid bits.
// arst_n clears all valid bits asynchronously; no request is in flight after reset.
// The receiver cannot stall; each result appears for exactly one cycle.
module float_format_converter_top import ffc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);
	s1_t s1_s1;
	s2_t s2_s2;
	logic        vld_s3;
	logic [31:0] res_s3;
	s1_t n1;
	s2_t n2;
	logic [31:0] n3;
	logic [31:0] rem_mask, half, rem;
	logic [23:0] mant;

	assign busy = 1'b0;

	// Stage 1: classify, compute the rounding shift and find the leading one.
	always_comb begin
		n1 = '0;
		n1.vld = start;
		n1.cmd = cmd;
		n1.op = operand_bits;
		n1.is_nan = (operand_bits[30:23] == 8'hFF) && (operand_bits[22:0] != '0);
		n1.is_inf = (operand_bits[30:23] == 8'hFF) && (operand_bits[22:0] == '0);
		n1.is_zero = (operand_bits[30:0] == '0);
		n1.msb = '0;
		if (cmd == CMD_F32_F16) begin
			n1.ee = $signed({2'b00, operand_bits[30:23]}) - 10'sd112;
			if (n1.ee > 0) n1.sh = 6'd13;
			else if (n1.ee < -10'sd10) n1.sh = 6'd32;
			else n1.sh = 6'(10'sd14 - n1.ee);
		end else if (cmd == CMD_F32_E4M3) begin
			n1.ee = $signed({2'b00, operand_bits[30:23]}) - 10'sd120;
			if (n1.ee > 0) n1.sh = 6'd20;
			else if (n1.ee < -10'sd3) n1.sh = 6'd32;
			else n1.sh = 6'(10'sd21 - n1.ee);
		end else if (cmd == CMD_E4M3_F32) begin
			n1.ee = '0;
			n1.sh = '0;
			for (int i = 0; i < 3; i++)
				if (operand_bits[i]) n1.msb = 5'(i);
		end else begin
			n1.ee = '0;
			n1.sh = '0;
			for (int i = 0; i < 10; i++)
				if (operand_bits[i]) n1.msb = 5'(i);
		end
	end

	// Stage 2: shift and decide rounding, or pass on the leading-one position.
	always_comb begin
		n2 = '0;
		n2.vld = s1_s1.vld;
		n2.cmd = s1_s1.cmd;
		n2.op = s1_s1.op;
		n2.is_nan = s1_s1.is_nan;
		n2.is_inf = s1_s1.is_inf;
		n2.is_zero = s1_s1.is_zero;
		n2.ee = s1_s1.ee;
		mant = (s1_s1.ee > 0) ? {1'b0, s1_s1.op[22:0]} : {1'b1, s1_s1.op[22:0]};
		rem_mask = '0;
		half = '0;
		rem = '0;
		if (s1_s1.cmd == CMD_F32_F16 || s1_s1.cmd == CMD_F32_E4M3) begin
			if (s1_s1.sh >= 6'd32) begin
				n2.t = '0;
			end else begin
				n2.t = 25'({8'd0, mant} >> s1_s1.sh);
				rem_mask = (32'd1 << s1_s1.sh) - 32'd1;
				half = 32'd1 << (s1_s1.sh - 6'd1);
				rem = {8'd0, mant} & rem_mask;
				n2.rup = (rem > half) || ((rem == half) && n2.t[0]);
			end
		end else begin
			n2.t = 25'(s1_s1.msb);
		end
	end

	// Stage 3: assemble the result.
	always_comb begin
		logic [15:0] hs;
		logic [7:0]  es;
		logic [24:0] m;
		logic signed [9:0] e;
		logic [9:0]  pl;
		logic [4:0]  p;
		logic [31:0] b;
		hs = {s2_s2.op[31], 15'd0};
		es = {s2_s2.op[31], 7'd0};
		m = s2_s2.t + 25'(s2_s2.rup);
		e = s2_s2.ee;
		p = s2_s2.t[4:0];
		b = s2_s2.op;
		pl = '0;
		n3 = '0;
		case (s2_s2.cmd)
			CMD_F32_F16: begin
				if (s2_s2.is_nan) begin
					pl = s2_s2.op[22:13];
					if (pl == '0) pl = 10'd1;
					n3 = {16'd0, hs | 16'h7C00 | {6'd0, pl}};
				end else if (s2_s2.is_inf || e >= 10'sd31) n3 = {16'd0, hs | 16'h7C00};
				else if (e <= 0) begin
					if (e < -10'sd10) n3 = {16'd0, hs};
					else n3 = {16'd0, hs | 16'(m)};
				end else if (m >= 25'h400) begin
					if (e + 10'sd1 >= 10'sd31) n3 = {16'd0, hs | 16'h7C00};
					else n3 = {16'd0, hs | {1'b0, 5'(e + 10'sd1), 10'd0}};
				end else n3 = {16'd0, hs | {1'b0, 5'(e), m[9:0]}};
			end
			CMD_F16_F32: begin
				if (b[14:10] == 5'd0) begin
					if (b[9:0] == '0) n3 = {b[15], 31'd0};
					else n3 = {b[15], 8'(8'd103 + {3'd0, p}),
						23'({13'd0, b[9:0] ^ (10'd1 << p)} << (5'd23 - p))};
				end else if (b[14:10] == 5'h1F) n3 = {b[15], 8'hFF, b[9:0], 13'd0};
				else n3 = {b[15], 8'({3'd0, b[14:10]} + 8'd112), b[9:0], 13'd0};
			end
			CMD_F32_BF16: begin
				if (b[30:23] == 8'hFF) begin
					if (b[22:0] != '0) b[16] = 1'b1;
					n3 = {b[31:16], 16'd0};
				end else begin
					b = b + 32'h7FFF + {31'd0, b[16]};
					n3 = {b[31:16], 16'd0};
				end
			end
			CMD_F32_E4M3: begin
				if (s2_s2.is_nan) n3 = {24'd0, es | 8'h7F};
				else if (s2_s2.is_inf) n3 = {24'd0, es | 8'h7E};
				else if (s2_s2.is_zero) n3 = {24'd0, es};
				else if (e >= 10'sd16) n3 = {24'd0, es | 8'h7E};
				else if (e <= 0) begin
					if (e < -10'sd3) n3 = {24'd0, es};
					else n3 = {24'd0, es | 8'(m)};
				end else begin
					if (m >= 25'd8) begin
						m = '0;
						e = e + 10'sd1;
					end
					if (e >= 10'sd16 || (e == 10'sd15 && m == 25'd7))
						n3 = {24'd0, es | 8'h7E};
					else n3 = {24'd0, es | {1'b0, 4'(e), m[2:0]}};
				end
			end
			CMD_E4M3_F32: begin
				if (b[6:3] == 4'd0) begin
					if (b[2:0] == '0) n3 = {b[7], 31'd0};
					else n3 = {b[7], 8'(8'd118 + {3'd0, p}),
						23'({20'd0, b[2:0] ^ 3'(3'd1 << p)} << (5'd23 - p))};
				end else if (b[6:0] == 7'h7F) n3 = {b[7], 31'h7FC00000};
				else n3 = {b[7], 8'({4'd0, b[6:3]} + 8'd120), b[2:0], 20'd0};
			end
			default: n3 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s1 <= '0;
			s2_s2 <= '0;
			vld_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			s1_s1 <= n1;
			s2_s2 <= n2;
			vld_s3 <= s2_s2.vld;
			done <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= n3;
		result_bits <= res_s3;
	end
endmodule
